// ===== hdl/accel_crash_detector_sma_assert.svh =====
// assertion macros used by the checker file
`ifndef ACCEL_CRASH_DETECTOR_SMA_ASSERT_SVH
`define ACCEL_CRASH_DETECTOR_SMA_ASSERT_SVH

// same-cycle implication
`define ACD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crash detector check failed");

// next-cycle implication
`define ACD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crash detector check failed");

`endif

// ===== hdl/acd_pkg.sv =====
package acd_pkg;

  localparam int WINDOW_LEN_DEF = 16;
  localparam int AXIS_W         = 13;
  localparam int MAG_W          = 13;
  localparam int THR_W          = 13;
  localparam logic [THR_W-1:0] THR_RESET = 13'd1024;

  // sum of three squared axes
  localparam int SQ_W       = 2 * AXIS_W;
  localparam int SQ_STEPS   = 3;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int ROOT_REM_W = MAG_W + 3;
  localparam int DIV_STEPS  = MAG_W;
  localparam int STEP_W     = 4;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_ROOT   = 6'b000100,
    ST_UPDATE = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_FINISH = 6'b100000
  } acd_state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic root;
    logic update;
    logic divide;
    logic finish;
  } acd_cmd_t;

endpackage

// ===== hdl/acd_sample_if.sv =====
interface acd_sample_if import acd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [AXIS_W-1:0] accel_x;
  logic signed [AXIS_W-1:0] accel_y;
  logic signed [AXIS_W-1:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

// ===== hdl/acd_result_if.sv =====
interface acd_result_if import acd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic [MAG_W-1:0] filtered_magnitude;
  logic             crash;

  modport source (output valid, magnitude, filtered_magnitude, crash, input ready);
  modport sink   (input valid, magnitude, filtered_magnitude, crash, output ready);
endinterface

// ===== hdl/accel_crash_detector_sma.sv =====
// steps per item: load, square, root, update, divide, finish, then back to idle
// a new item is taken only in idle, one item at a time; finish waits until the result register is free
// the square root and divider loops work one bit a step on shared units
// reset (rst, synchronous): window sum, write index and full flag cleared, threshold 1024
// unwritten ring entries read as zero through the full flag, so no clearing pass
module accel_crash_detector_sma import acd_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [THR_W-1:0]  cfg_data,
  acd_sample_if.sink        sample,
  acd_result_if.source      result
);

  // command bundle from the sequencer to the datapath
  acd_cmd_t cmd;

  // sequencer: one item in flight, output register parts the result side
  acd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  // datapath: squarer, square root, ring average, divider and crash compare
  acd_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .accel_x            (sample.accel_x),
    .accel_y            (sample.accel_y),
    .accel_z            (sample.accel_z),
    .magnitude          (result.magnitude),
    .filtered_magnitude (result.filtered_magnitude),
    .crash              (result.crash)
  );

endmodule

// ===== hdl/acd_ram.sv =====
module acd_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/acd_datapath.sv =====
module acd_datapath import acd_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  acd_cmd_t                 cmd,
  input  logic                     cfg_we,
  input  logic [THR_W-1:0]         cfg_data,
  input  logic signed [AXIS_W-1:0] accel_x,
  input  logic signed [AXIS_W-1:0] accel_y,
  input  logic signed [AXIS_W-1:0] accel_z,
  output logic [MAG_W-1:0]         magnitude,
  output logic [MAG_W-1:0]         filtered_magnitude,
  output logic                     crash
);

  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = MAG_W + $clog2(WINDOW_LEN);
  localparam int REM_W = CNT_W + 1;
  localparam int DQ_W  = REM_W + MAG_W;
  localparam int CMP_W = 16 + CNT_W;
  localparam int PRD_W = THR_W + 2 + CNT_W;

  function automatic logic [AXIS_W-1:0] axis_abs(input logic [AXIS_W-1:0] v);
    return v[AXIS_W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [AXIS_W-1:0]     ax, ay, az;
  logic [SQ_W-1:0]       acc;
  logic [ROOT_REM_W-1:0] rem;
  logic [MAG_W-1:0]      root;
  logic [SUM_W-1:0]      sum;
  logic [IDX_W-1:0]      widx;
  logic                  full;
  logic [CNT_W-1:0]      count;
  logic [DQ_W-1:0]       dq;
  logic [CMP_W-1:0]      lhs, rhs;
  logic [THR_W-1:0]      threshold;
  logic [MAG_W-1:0]      ram_rdata;

  logic [SQ_W-1:0]         sq;
  logic [ROOT_REM_W+1:0]   root_t, root_trial;
  logic [MAG_W-1:0]        old_mag;
  logic [SUM_W-1:0]        sum_next;
  logic                    wrap;
  logic [IDX_W-1:0]        widx_next;
  logic                    full_next;
  logic [CNT_W-1:0]        count_next;
  logic [REM_W-1:0]        rem_sh;
  logic [PRD_W-1:0]        prod;

  always_comb begin
    sq         = ax * ax;
    root_t     = {rem, acc[SQ_W-1 -: 2]};
    root_trial = (ROOT_REM_W + 2)'({root, 2'b01});
    old_mag    = full ? ram_rdata : '0;
    sum_next   = sum - SUM_W'(old_mag) + SUM_W'(root);
    wrap       = (widx == IDX_W'(WINDOW_LEN - 1));
    widx_next  = wrap ? '0 : widx + 1'b1;
    full_next  = full | wrap;
    count_next = full_next ? CNT_W'(WINDOW_LEN) : CNT_W'(widx_next);
    rem_sh     = dq[DQ_W-2 -: REM_W];
    prod       = {threshold, 2'b00} * count;
  end

  acd_ram #(
    .WIDTH (MAG_W),
    .DEPTH (WINDOW_LEN)
  ) u_window_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (widx),
    .wdata (root),
    .raddr (widx),
    .rdata (ram_rdata)
  );

  // window state and threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      widx      <= '0;
      full      <= 1'b0;
      threshold <= THR_RESET;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_data;
      end
      if (cmd.update) begin
        sum  <= sum_next;
        widx <= widx_next;
        full <= full_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax   <= axis_abs(accel_x);
      ay   <= axis_abs(accel_y);
      az   <= axis_abs(accel_z);
      acc  <= '0;
      rem  <= '0;
      root <= '0;
    end
    if (cmd.square) begin
      acc <= acc + sq;
      ax  <= ay;
      ay  <= az;
    end
    if (cmd.root) begin
      acc <= {acc[SQ_W-3:0], 2'b00};
      if (root_t >= root_trial) begin
        rem  <= ROOT_REM_W'(root_t - root_trial);
        root <= {root[MAG_W-2:0], 1'b1};
      end else begin
        rem  <= ROOT_REM_W'(root_t);
        root <= {root[MAG_W-2:0], 1'b0};
      end
    end
    if (cmd.update) begin
      count <= count_next;
      dq    <= DQ_W'(sum_next);
    end
    if (cmd.divide) begin
      lhs <= CMP_W'(sum) + CMP_W'({sum, 2'b00});
      rhs <= CMP_W'(prod);
      if (rem_sh >= REM_W'(count)) begin
        dq <= {rem_sh - REM_W'(count), dq[MAG_W-2:0], 1'b1};
      end else begin
        dq <= {rem_sh, dq[MAG_W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      magnitude          <= root;
      filtered_magnitude <= dq[MAG_W-1:0];
      crash              <= (root >= threshold) || (lhs >= rhs);
    end
  end

endmodule

// ===== hdl/acd_ctrl.sv =====
module acd_ctrl import acd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output acd_cmd_t cmd
);

  acd_state_t        state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SQUARE;
          step_next  = '0;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        if (step == STEP_W'(SQ_STEPS - 1)) begin
          state_next = ST_ROOT;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.root = 1'b1;
        if (step == STEP_W'(ROOT_STEPS - 1)) begin
          state_next = ST_UPDATE;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DIVIDE;
        step_next  = '0;
      end
      ST_DIVIDE: begin
        cmd.divide = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_FINISH;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/acd_checker.sv =====
`include "accel_crash_detector_sma_assert.svh"

module acd_checker import acd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [MAG_W-1:0] magnitude,
  input logic [MAG_W-1:0] filtered_magnitude,
  input logic             crash
);

  // busy straight after taking an item
  `ACD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // no fresh result shortly after an item is taken
  `ACD_ASSERT_NEXT(a_no_early_result, clk, rst, in_valid && in_ready, !$rose(out_valid) ##1 !$rose(out_valid))

  // out of reset: empty and ready
  `ACD_ASSERT_NOW(a_reset_state, clk, rst, $past(rst), !out_valid && in_ready)

  // stalled result holds
  `ACD_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(magnitude) && $stable(filtered_magnitude) && $stable(crash))

endmodule

bind accel_crash_detector_sma acd_checker u_acd_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (sample.valid),
  .in_ready           (sample.ready),
  .out_valid          (result.valid),
  .out_ready          (result.ready),
  .magnitude          (result.magnitude),
  .filtered_magnitude (result.filtered_magnitude),
  .crash              (result.crash)
);

// ===== tb/sv/accel_crash_detector_sma_test.sv =====
module accel_crash_detector_sma_test import acd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // ring length of the instance under test (default parameter)
  localparam int RING_LEN = WINDOW_LEN_DEF;
  localparam int POS_W    = $clog2(RING_LEN);

  // raw 13 bit axis values, bit 12 is the sign
  typedef struct {
    logic [AXIS_W-1:0] x;
    logic [AXIS_W-1:0] y;
    logic [AXIS_W-1:0] z;
  } sample_t;

  // what the block should report for one sample
  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic [MAG_W-1:0] average;
    logic             crash;
  } crash_report_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_data;

  acd_sample_if sample_ch ();
  acd_result_if result_ch ();

  accel_crash_detector_sma dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .sample   (sample_ch.sink),
    .result   (result_ch.source)
  );

  always #5 clk = ~clk;

  // predictor copy of the block state
  logic [MAG_W-1:0] ring_mags [RING_LEN];
  logic [16:0]      ring_total;
  logic [POS_W-1:0] ring_pos;
  logic             ring_wrapped;
  logic [THR_W-1:0] crash_level;

  // reports predicted at sample acceptance, oldest first
  crash_report_t pending_reports[$];
  crash_report_t oldest_report;

  // idle and stall knobs, percent
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long result hold-off, counted down by the ready process
  int hold_off_cycles = 0;

  // run statistics
  int samples_sent    = 0;
  int reports_checked = 0;
  int crashes_seen    = 0;
  int level_writes    = 0;
  int mismatch_count  = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // size of a two's complement axis; -4096 gives 4096
  function automatic logic [AXIS_W-1:0] axis_size(input logic [AXIS_W-1:0] raw);
    return raw[AXIS_W-1] ? AXIS_W'(14'h2000 - raw) : raw;
  endfunction

  // floor square root, one result bit per pass from the top
  function automatic logic [MAG_W-1:0] floor_root(input logic [31:0] energy);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= energy) root = trial;
    end
    return root[MAG_W-1:0];
  endfunction

  // push one magnitude into the moving window and form the report
  function automatic crash_report_t next_crash_report(input sample_t s);
    crash_report_t r;
    logic [AXIS_W-1:0] ax, ay, az;
    logic [31:0]       energy;
    logic [31:0]       count;
    ax = axis_size(s.x);
    ay = axis_size(s.y);
    az = axis_size(s.z);
    energy = ax * ax + ay * ay + az * az;
    r.magnitude = floor_root(energy);
    ring_total = ring_total - ring_mags[ring_pos] + r.magnitude;
    ring_mags[ring_pos] = r.magnitude;
    if (ring_pos == POS_W'(RING_LEN - 1)) begin
      ring_pos = '0;
      ring_wrapped = 1'b1;
    end else begin
      ring_pos = ring_pos + 1'b1;
    end
    count = ring_wrapped ? 32'(RING_LEN) : 32'(ring_pos);
    r.average = MAG_W'(32'(ring_total) / count);
    // exact ratio compare, not the truncated average
    r.crash = (r.magnitude >= crash_level) ||
              (32'(ring_total) * 5 >= 32'(crash_level) * 4 * count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sample_t axes(input int x, input int y, input int z);
    sample_t s;
    s.x = AXIS_W'(x);
    s.y = AXIS_W'(y);
    s.z = AXIS_W'(z);
    return s;
  endfunction

  // random sample, in part shaped around the crash level or its 4/5 mark
  function automatic sample_t pick_sample(input logic [THR_W-1:0] level);
    sample_t s;
    int target;
    int share;
    int corner [4];
    corner = '{-4096, 4095, 0, -1};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        s.x = AXIS_W'($urandom);
        s.y = AXIS_W'($urandom);
        s.z = AXIS_W'($urandom);
      end
      4, 5, 6, 7: begin
        target = $urandom_range(0, 1) ? int'(level) : int'(level) * 4 / 5;
        target = target + $urandom_range(0, 64) - 32;
        if (target < 0) target = 0;
        if (target <= 4095 && $urandom_range(0, 1)) begin
          // mostly on one axis, a little noise on the others
          s = axes($urandom_range(0, 1) ? -target : target,
                   $urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8);
        end else begin
          // spread evenly, roughly target / sqrt(3) per axis
          share = target * 148 / 256;
          if (share > 4095) share = 4095;
          s = axes($urandom_range(0, 1) ? -share : share,
                   $urandom_range(0, 1) ? -share : share,
                   $urandom_range(0, 1) ? -share : share);
        end
      end
      8: begin
        s = axes(corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)],
                 corner[$urandom_range(0, 3)]);
      end
      default: begin
        s = axes($urandom_range(0, 31) - 16, $urandom_range(0, 31) - 16,
                 $urandom_range(0, 31) - 16);
      end
    endcase
    return s;
  endfunction

  // offer one sample from a falling edge; valid is left high on return so that
  // back-to-back items need no drop, the caller lowers it with stop_samples
  task automatic send_sample(input sample_t s);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      // idle spans long enough to land on every stage of the block's work
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 48)) @(negedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.accel_x <= s.x;
    sample_ch.accel_y <= s.y;
    sample_ch.accel_z <= s.z;
    do @(posedge clk); while (!sample_ch.ready);
    pending_reports.push_back(next_crash_report(s));
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic stop_samples();
    sample_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // threshold is written only with nothing in flight
  task automatic write_crash_level(input logic [THR_W-1:0] level);
    stop_samples();
    while (pending_reports.size() != 0) @(negedge clk);
    cfg_data <= level;
    cfg_we   <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    crash_level = level;
    level_writes++;
  endtask

  task automatic set_idling(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // receiver readiness: random stalls, or a counted long hold-off
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      result_ch.ready <= 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result magnitude", result_ch.magnitude, -1);
      end else begin
        oldest_report = pending_reports.pop_front();
        reports_checked++;
        if (result_ch.crash) crashes_seen++;
        if (result_ch.magnitude !== oldest_report.magnitude)
          report_mismatch("magnitude", result_ch.magnitude, oldest_report.magnitude);
        if (result_ch.filtered_magnitude !== oldest_report.average)
          report_mismatch("filtered_magnitude", result_ch.filtered_magnitude,
                          oldest_report.average);
        if (result_ch.crash !== oldest_report.crash)
          report_mismatch("crash", result_ch.crash, oldest_report.crash);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset threshold of 4 g, axis extremes, exact root and the threshold edge
  task automatic test_axis_extremes();
    send_sample(axes(0, 0, 0));
    send_sample(axes(-4096, -4096, -4096));
    send_sample(axes(4095, 4095, 4095));
    send_sample(axes(-4096, 0, 0));
    send_sample(axes(0, 4095, -1));
    send_sample(axes(3, -4, 0));
    send_sample(axes(1024, 0, 0));
    send_sample(axes(0, -1023, 0));
    stop_samples();
  endtask

  // zero threshold: crash must always be raised
  task automatic test_zero_level();
    write_crash_level('0);
    send_sample(axes(0, 0, 0));
    send_sample(axes(1, -1, 1));
    stop_samples();
  endtask

  // top threshold: the magnitude alone can never reach it
  task automatic test_top_level();
    write_crash_level('1);
    send_sample(axes(-4096, -4096, -4096));
    send_sample(axes(4095, -4096, 4095));
    stop_samples();
  endtask

  // run the window through its wrap with magnitudes on the 4/5 mark
  task automatic test_window_wrap();
    write_crash_level(THR_W'(1000));
    for (int i = 0; i < 12; i++)
      send_sample(i[0] ? axes(0, -799, 0) : axes(800, 0, 0));
    stop_samples();
  endtask

  // random samples under each idling mix, two thresholds per mix
  task automatic test_random_mixes();
    int idle_mix  [4];
    int stall_mix [4];
    idle_mix  = '{0, 50, 0, 34};
    stall_mix = '{0, 0, 50, 34};
    for (int m = 0; m < 4; m++) begin
      for (int half = 0; half < 2; half++) begin
        case ($urandom_range(0, 2))
          0:       write_crash_level(THR_W'($urandom_range(200, 2000)));
          1:       write_crash_level(THR_W'($urandom));
          default: write_crash_level(THR_W'($urandom_range(4000, 8191)));
        endcase
        set_idling(idle_mix[m], stall_mix[m]);
        for (int i = 0; i < 60; i++) send_sample(pick_sample(crash_level));
        stop_samples();
      end
    end
    set_idling(0, 0);
  endtask

  // results held off for a long stretch while samples keep coming
  task automatic test_result_hold_off();
    write_crash_level(THR_W'($urandom_range(500, 1500)));
    @(posedge clk);
    hold_off_cycles = 400;
    @(negedge clk);
    for (int i = 0; i < 20; i++) send_sample(pick_sample(crash_level));
    stop_samples();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_data          <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.accel_x <= '0;
    sample_ch.accel_y <= '0;
    sample_ch.accel_z <= '0;

    // predictor starts from the reset state
    for (int i = 0; i < RING_LEN; i++) ring_mags[i] = '0;
    ring_total   = '0;
    ring_pos     = '0;
    ring_wrapped = 1'b0;
    crash_level  = THR_RESET;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_axis_extremes();
    test_zero_level();
    test_top_level();
    test_window_wrap();
    test_random_mixes();
    test_result_hold_off();

    // drain, then keep watching for stray results
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("covered %0d samples under %0d threshold writes (0 and 8191 among them),",
             samples_sent, level_writes);
    $display("idle and stall mixes and a long result hold-off; %0d results, %0d crash",
             reports_checked, crashes_seen);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // generous bound on the whole run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_reports.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== accel_crash_detector_sma.f =====
+incdir+hdl
hdl/acd_pkg.sv
hdl/acd_sample_if.sv
hdl/acd_result_if.sv
hdl/acd_ram.sv
hdl/acd_datapath.sv
hdl/acd_ctrl.sv
hdl/accel_crash_detector_sma.sv
hdl/acd_checker.sv
tb/sv/accel_crash_detector_sma_test.sv
